// ===== rtl/core/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, character slot codes and digit helpers for the HEX encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    // One classified input item, as queued between front and back.
    typedef struct packed {
        logic        eof;
        logic        hdr;
        logic        trl;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  rtype;
        logic [7:0]  data;
        logic [7:0]  csum;
    } cmd_t;

    typedef logic [3:0] slot_t;

    // Character slots of a data record line.
    localparam slot_t SlotColon   = 4'd0;
    localparam slot_t SlotLenHi   = 4'd1;
    localparam slot_t SlotLenLo   = 4'd2;
    localparam slot_t SlotAddr3   = 4'd3;
    localparam slot_t SlotAddr2   = 4'd4;
    localparam slot_t SlotAddr1   = 4'd5;
    localparam slot_t SlotAddr0   = 4'd6;
    localparam slot_t SlotTypeHi  = 4'd7;
    localparam slot_t SlotTypeLo  = 4'd8;
    localparam slot_t SlotDataHi  = 4'd9;
    localparam slot_t SlotDataLo  = 4'd10;
    localparam slot_t SlotCsumHi  = 4'd11;
    localparam slot_t SlotCsumLo  = 4'd12;
    localparam slot_t SlotNewline = 4'd13;

    // Slots of the end-of-file line, other than the colon, that are not '0'.
    localparam slot_t SlotEofOne  = 4'd8;
    localparam slot_t SlotEofF1   = 4'd9;
    localparam slot_t SlotEofF0   = 4'd10;
    localparam slot_t SlotEofLast = 4'd11;

    localparam logic [6:0] ChColon   = 7'h3A;
    localparam logic [6:0] ChZero    = 7'h30;
    localparam logic [6:0] ChOne     = 7'h31;
    localparam logic [6:0] ChF       = 7'h46;
    localparam logic [6:0] ChNewline = 7'h0A;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ext;
        ext = {3'b000, nib};
        hex_char = (nib < 4'd10) ? (ChZero + ext) : (7'h37 + ext);
    endfunction

    // ":00000001FF" followed by newline
    function automatic logic [6:0] eof_char(input slot_t slot);
        logic [6:0] ch;
        unique case (slot)
            SlotColon:            ch = ChColon;
            SlotEofOne:           ch = ChOne;
            SlotEofF1, SlotEofF0: ch = ChF;
            SlotEofLast:          ch = ChNewline;
            default:              ch = ChZero;
        endcase
        eof_char = ch;
    endfunction

endpackage

// ===== rtl/core/ihex_front.sv =====
// ----------------------------------------------------------------------------
// ihex_front
// Accepts input transfers, tracks the open record and its checksum, and
// classifies each item into a command for the character sequencer.
// ----------------------------------------------------------------------------
module ihex_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         data_byte,
    input  logic [15:0]        record_address,
    input  logic [7:0]         record_length,
    input  logic [7:0]         record_type,
    input  logic               q_full,
    output logic               q_push,
    output ihex_pkg::cmd_t     q_cmd
);

    logic [7:0] bytes_done_reg, bytes_done_next;
    logic [7:0] length_reg,     length_next;
    logic [7:0] csum_reg,       csum_next;

    logic       rec_open;
    logic [7:0] len_eff;
    logic [7:0] len_cur;
    logic [7:0] sum_base;
    logic [7:0] sum_new;
    logic [7:0] done_new;
    logic       closing;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign rec_open = (bytes_done_reg != 8'd0);
    assign len_eff  = (record_length == 8'd0) ? 8'd1 : record_length;
    assign len_cur  = rec_open ? length_reg : len_eff;
    assign sum_base = rec_open ? csum_reg
                    : len_eff + record_address[15:8] + record_address[7:0] + record_type;
    assign sum_new  = sum_base + data_byte;
    assign done_new = bytes_done_reg + 8'd1;
    assign closing  = (done_new == len_cur);

    always_comb begin
        q_cmd.eof   = action;
        q_cmd.hdr   = !action && !rec_open;
        q_cmd.trl   = !action && closing;
        q_cmd.len   = len_eff;
        q_cmd.addr  = record_address;
        q_cmd.rtype = record_type;
        q_cmd.data  = data_byte;
        q_cmd.csum  = 8'd0 - sum_new;
    end

    always_comb begin
        bytes_done_next = bytes_done_reg;
        length_next     = length_reg;
        csum_next       = csum_reg;
        if (q_push) begin
            if (action || closing) begin
                bytes_done_next = 8'd0;
                length_next     = 8'd0;
                csum_next       = 8'd0;
            end else begin
                bytes_done_next = done_new;
                length_next     = len_cur;
                csum_next       = sum_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_done_reg <= 8'd0;
            length_reg     <= 8'd0;
            csum_reg       <= 8'd0;
        end else begin
            bytes_done_reg <= bytes_done_next;
            length_reg     <= length_next;
            csum_reg       <= csum_next;
        end
    end

endmodule

// ===== rtl/core/ihex_fifo.sv =====
// ----------------------------------------------------------------------------
// ihex_fifo
// Small command queue between the front and the character sequencer.
// ----------------------------------------------------------------------------
module ihex_fifo #(
    parameter int Depth = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ihex_pkg::cmd_t     push_cmd,
    output logic               full,
    input  logic               pop,
    output ihex_pkg::cmd_t     pop_cmd,
    output logic               empty
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    ihex_pkg::cmd_t  entries_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;

    assign full    = (count_reg == CntFull);
    assign empty   = (count_reg == '0);
    assign pop_cmd = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntFull)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CntFull) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/ihex_back.sv =====
// ----------------------------------------------------------------------------
// ihex_back
// Character sequencer: walks the slots of the queue-head command and emits one
// ASCII character per cycle unless stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module ihex_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  ihex_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         out_char,
    output logic               out_last
);

    logic                started_reg, started_next;
    ihex_pkg::slot_t     slot_reg,    slot_next;
    logic                valid_reg,   valid_next;
    logic [6:0]          char_reg,    char_next;
    logic                last_reg,    last_next;

    ihex_pkg::slot_t     first_slot;
    ihex_pkg::slot_t     last_slot;
    ihex_pkg::slot_t     cur_slot;
    logic [6:0]          data_ch;
    logic [6:0]          cur_ch;
    logic                emit;
    logic                at_end;

    assign first_slot = (q_cmd.eof || q_cmd.hdr) ? ihex_pkg::SlotColon : ihex_pkg::SlotDataHi;
    assign last_slot  = q_cmd.eof ? ihex_pkg::SlotEofLast
                      : (q_cmd.trl ? ihex_pkg::SlotNewline : ihex_pkg::SlotDataLo);
    assign cur_slot   = started_reg ? slot_reg : first_slot;
    assign at_end     = (cur_slot == last_slot);
    assign emit       = !q_empty && (!valid_reg || out_ready);
    assign q_pop      = emit && at_end;

    always_comb begin
        unique case (cur_slot)
            ihex_pkg::SlotColon:  data_ch = ihex_pkg::ChColon;
            ihex_pkg::SlotLenHi:  data_ch = ihex_pkg::hex_char(q_cmd.len[7:4]);
            ihex_pkg::SlotLenLo:  data_ch = ihex_pkg::hex_char(q_cmd.len[3:0]);
            ihex_pkg::SlotAddr3:  data_ch = ihex_pkg::hex_char(q_cmd.addr[15:12]);
            ihex_pkg::SlotAddr2:  data_ch = ihex_pkg::hex_char(q_cmd.addr[11:8]);
            ihex_pkg::SlotAddr1:  data_ch = ihex_pkg::hex_char(q_cmd.addr[7:4]);
            ihex_pkg::SlotAddr0:  data_ch = ihex_pkg::hex_char(q_cmd.addr[3:0]);
            ihex_pkg::SlotTypeHi: data_ch = ihex_pkg::hex_char(q_cmd.rtype[7:4]);
            ihex_pkg::SlotTypeLo: data_ch = ihex_pkg::hex_char(q_cmd.rtype[3:0]);
            ihex_pkg::SlotDataHi: data_ch = ihex_pkg::hex_char(q_cmd.data[7:4]);
            ihex_pkg::SlotDataLo: data_ch = ihex_pkg::hex_char(q_cmd.data[3:0]);
            ihex_pkg::SlotCsumHi: data_ch = ihex_pkg::hex_char(q_cmd.csum[7:4]);
            ihex_pkg::SlotCsumLo: data_ch = ihex_pkg::hex_char(q_cmd.csum[3:0]);
            default:              data_ch = ihex_pkg::ChNewline;
        endcase
    end

    assign cur_ch = q_cmd.eof ? ihex_pkg::eof_char(cur_slot) : data_ch;

    always_comb begin
        started_next = started_reg;
        slot_next    = slot_reg;
        valid_next   = valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (emit) begin
            valid_next = 1'b1;
            char_next  = cur_ch;
            last_next  = at_end;
            if (at_end) begin
                started_next = 1'b0;
            end else begin
                started_next = 1'b1;
                slot_next    = cur_slot + 4'd1;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

`ifndef SYNTHESIS
    a_started_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> !q_empty)
        else $error("sequencer started without a queued command");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> (slot_reg <= last_slot))
        else $error("sequencer slot past end of line");

    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (valid_reg && last_reg && !started_reg))
        else $error("pop without final character");
`endif

endmodule

// ===== rtl/core/intel_hex_record_encoder.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// Turns a stream of data bytes into Intel HEX text, one ASCII character per
// output transfer.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                       tuser    tlast
//  s_        in   data/address/length/type    action   -
//  m_        out  character                   -        last_of_run
//
//  One character per cycle unless stalled: a data byte makes 2 characters, plus
//  9 for a record header and 3 for the checksum trailer; end of file makes 12.
//  The character sequencer sets that rate; the front takes one item a cycle
//  until the command queue (QUEUE_DEPTH entries) fills.
//  Reset is synchronous, active low, and closes any open record.
//  m_tready low holds the output register; s_tready drops only on a full queue.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [23:8] record_address, [31:24] record_length,
    // [39:32] record_type
    input  logic [39:0] s_tdata,
    // [0] action
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] character, [7] zero
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    ihex_pkg::cmd_t push_cmd;
    ihex_pkg::cmd_t head_cmd;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic [6:0]     out_char;

    ihex_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .action         (s_tuser[0]),
        .data_byte      (s_tdata[7:0]),
        .record_address (s_tdata[23:8]),
        .record_length  (s_tdata[31:24]),
        .record_type    (s_tdata[39:32]),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    ihex_fifo #(
        .Depth (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (head_cmd),
        .empty    (q_empty)
    );

    ihex_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

// ===== dv/tb_intel_hex_record_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_intel_hex_record_encoder
// Self-checking bench for the Intel HEX text encoder. Data-byte and end-of-file
// items go in on the input stream with random gaps. Every output character is
// compared, with its end-of-run flag, against the text predicted from the
// items accepted so far. The output side applies random back-pressure.
// ----------------------------------------------------------------------------

typedef enum bit {
    ACT_DATA = 1'b0,
    ACT_EOF  = 1'b1
} hex_action_e;

typedef struct {
    logic [6:0] ch;
    logic       last;
} text_char_t;

class hex_text_board;
    bit [7:0]   bytes_in_rec;
    bit [7:0]   rec_len;
    bit [7:0]   rec_sum;
    text_char_t due[$];
    logic [6:0] run_chars[$];
    int         mismatches;
    int         chars_checked;
    int         records_closed;
    int         eof_lines;

    function logic [6:0] digit(bit [3:0] nib);
        if (nib < 4'd10)
            return 7'(ihex_pkg::ChZero + nib);
        return 7'(7'h41 + nib - 4'd10);
    endfunction

    function void put_hex(bit [7:0] v);
        run_chars.push_back(digit(v[7:4]));
        run_chars.push_back(digit(v[3:0]));
    endfunction

    function void clear_record();
        bytes_in_rec = 8'd0;
        rec_len      = 8'd0;
        rec_sum      = 8'd0;
    endfunction

    // Predict the characters caused by one accepted input transfer.
    function void note_input(hex_action_e act, bit [7:0] data, bit [15:0] addr,
                             bit [7:0] len, bit [7:0] rtype);
        string eof_line;
        byte   ch;
        eof_line = ":00000001FF";
        run_chars.delete();
        if (act == ACT_EOF) begin
            clear_record();
            for (int i = 0; i < eof_line.len(); i++) begin
                ch = eof_line[i];
                run_chars.push_back(ch[6:0]);
            end
            run_chars.push_back(ihex_pkg::ChNewline);
            eof_lines++;
        end else begin
            if (bytes_in_rec == 8'd0) begin
                if (len == 8'd0)
                    len = 8'd1;
                rec_len = len;
                rec_sum = len + addr[15:8] + addr[7:0] + rtype;
                run_chars.push_back(ihex_pkg::ChColon);
                put_hex(len);
                put_hex(addr[15:8]);
                put_hex(addr[7:0]);
                put_hex(rtype);
            end
            put_hex(data);
            rec_sum      = rec_sum + data;
            bytes_in_rec = bytes_in_rec + 8'd1;
            if (bytes_in_rec == rec_len) begin
                put_hex(8'(0 - rec_sum));
                run_chars.push_back(ihex_pkg::ChNewline);
                clear_record();
                records_closed++;
            end
        end
        foreach (run_chars[i])
            due.push_back('{run_chars[i], (i == run_chars.size() - 1)});
    endfunction

    function void check_output(logic [7:0] tdata, logic tlast);
        text_char_t exp;
        chars_checked++;
        if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: unexpected character 0x%02h last=%0b", tdata, tlast);
            return;
        end
        exp = due.pop_front();
        if (tdata !== {1'b0, exp.ch} || tlast !== exp.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                         chars_checked, {1'b0, exp.ch}, exp.last, tdata, tlast);
        end
    endfunction

    function int pending();
        return due.size();
    endfunction
endclass

module tb_intel_hex_record_encoder;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 220;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [7:0] data_byte, [23:8] record_address, [31:24] record_length,
    // [39:32] record_type
    logic [39:0] s_tdata;
    // [0] action
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [6:0] character, [7] zero
    logic [7:0]  m_tdata;
    logic        m_tlast;

    hex_text_board board;
    int            items_sent;
    int            cycle_count;
    bit            src_steady;
    bit            sink_steady;

    intel_hex_record_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_item(hex_action_e act, bit [7:0] data, bit [15:0] addr,
                             bit [7:0] len, bit [7:0] rtype);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = 40'({$urandom, $urandom});
            s_tuser  = 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {rtype, len, addr, data};
        s_tuser  = act;
        do @(posedge aclk); while (!s_tready);
        board.note_input(act, data, addr, len, rtype);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_eof();
        send_item(ACT_EOF, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Opens a record of the given length and sends n_bytes of it; later bytes
    // carry junk in the header fields.
    task automatic send_record(bit [7:0] len, int n_bytes);
        send_item(ACT_DATA, 8'($urandom), 16'($urandom), len, 8'($urandom));
        for (int i = 1; i < n_bytes; i++)
            send_item(ACT_DATA, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Output back-pressure
    initial begin
        int run;
        int stall;
        m_tready = 1'b0;
        forever begin
            run   = $urandom_range(1, 12);
            stall = pick_gap(sink_steady);
            m_tready = 1'b1;
            repeat (run) @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_output(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, board.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int len;
        board       = new();
        items_sent  = 0;
        cycle_count = 0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: extremes, zero length, ignored header fields, early end of file
        send_eof();
        send_item(ACT_DATA, 8'hFF, 16'hFFFF, 8'd1, 8'hFF);
        send_item(ACT_DATA, 8'h00, 16'h0000, 8'd1, 8'h00);
        send_item(ACT_DATA, 8'hA5, 16'h1234, 8'd0, 8'h5A);
        send_item(ACT_DATA, 8'h0F, 16'h8000, 8'd3, 8'h80);
        send_item(ACT_DATA, 8'hF0, 16'h7FFF, 8'd0, 8'h7F);
        send_item(ACT_DATA, 8'h5A, 16'hFFFF, 8'd255, 8'hFF);
        send_item(ACT_DATA, 8'h80, 16'h00FF, 8'd255, 8'h01);
        send_item(ACT_DATA, 8'h7F, 16'hFF00, 8'd128, 8'h00);
        send_item(ACT_DATA, 8'h01, 16'hAAAA, 8'h55, 8'hAA);
        send_eof();
        send_eof();
        send_item(ACT_DATA, 8'h3C, 16'h5555, 8'd2, 8'h55);
        send_item(ACT_DATA, 8'hC3, 16'h0000, 8'd0, 8'h00);
        send_record(8'd4, 4);

        // Random: mostly well-formed records, some noise and broken records
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_eof();
            end else if (r < 16) begin
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 40)
                                                  : $urandom_range(128, 255);
                send_record(8'(len), $urandom_range(1, (len < 8) ? len - 1 : 6));
                send_eof();
            end else if (r < 20) begin
                send_record(8'd0, 1);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 8);
                else if (r < 95)
                    len = $urandom_range(9, 32);
                else
                    len = $urandom_range(33, 64);
                send_record(8'(len), len);
            end
        end
        s_tvalid = 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d items: %0d records closed, %0d end-of-file lines",
                 items_sent, board.records_closed, board.eof_lines);
        $display("checked %0d characters, %0d mismatches",
                 board.chars_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
